// ===== src/npag_pkg.sv =====
// Shared types and constants for the N-D permute address generator.
package npag_pkg;

  localparam int OFF_W      = 48;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 96;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_AXES   = 4;
  localparam int CFG_SIZE_W = 12;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_AXIS_SIZE_0  = 4'd0;
  localparam cfg_idx_t CFG_AXIS_SIZE_1  = 4'd1;
  localparam cfg_idx_t CFG_AXIS_SIZE_2  = 4'd2;
  localparam cfg_idx_t CFG_AXIS_SIZE_3  = 4'd3;
  localparam cfg_idx_t CFG_PERM_FIELDS  = 4'd4;
  localparam cfg_idx_t CFG_PERM_LENGTH  = 4'd5;
  localparam cfg_idx_t CFG_ARRAY_RANK   = 4'd6;
  localparam cfg_idx_t CFG_INVERSE_MODE = 4'd7;

  localparam logic [CFG_SIZE_W-1:0] RST_AXIS_SIZE   = 12'd1;
  localparam logic [15:0]           RST_PERM_FIELDS = 16'h4321;
  localparam logic [3:0]            RST_PERM_LENGTH = 4'd4;
  localparam logic [2:0]            RST_ARRAY_RANK  = 3'd2;
  localparam logic                  RST_INVERSE     = 1'b0;

  typedef struct packed {
    logic [CFG_AXES-1:0][CFG_SIZE_W-1:0] axis_size;
    logic [15:0]                         perm_fields;
    logic [3:0]                          perm_length;
    logic [2:0]                          array_rank;
    logic                                inverse_mode;
  } cfg_t;

  typedef enum logic {
    CMD_ADVANCE,
    CMD_RESTART
  } cmd_kind_t;

  typedef struct packed {
    logic      valid;
    cmd_kind_t kind;
  } cmd_t;

endpackage

// ===== src/npag_front.sv =====
// Input side: accepts transfers, classifies them and queues commands for the walker.
module npag_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // in_tdata: [0] restart, rest zero
  input  logic [npag_pkg::IN_DATA_W-1:0] in_tdata,
  output npag_pkg::cmd_t                 cmd,
  input  logic                           cmd_pop
);

  logic [1:0]          count_r, count_nxt;
  logic                head_r, head_nxt;
  logic                tail_r, tail_nxt;
  npag_pkg::cmd_kind_t slot_r [2];
  npag_pkg::cmd_kind_t kind_c;
  logic                push;

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign kind_c    = in_tdata[0] ? npag_pkg::CMD_RESTART : npag_pkg::CMD_ADVANCE;

  assign cmd.valid = (count_r != 2'd0);
  assign cmd.kind  = slot_r[head_r];

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (push) begin
      tail_nxt = ~tail_r;
    end
    if (cmd_pop) begin
      head_nxt = ~head_r;
    end
    if (push && !cmd_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && cmd_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 1'b0;
      tail_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
    if (push) begin
      slot_r[tail_r] <= kind_c;
    end
  end

endmodule

// ===== src/npag_back.sv =====
// Walker: checks the permutation, derives strides and steps the odometer per element.
module npag_back #(
  parameter int MAX_RANK  = 4,
  parameter int AXIS_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  npag_pkg::cfg_t                  cfg,
  input  npag_pkg::cmd_t                  cmd,
  output logic                            cmd_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata: [47:0] source_offset, [95:48] dest_offset
  output logic [npag_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  // out_tuser: [0] perm_error
  output logic                            out_tuser
);

  localparam int PW       = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int RANK_CAP = (MAX_RANK < 4) ? MAX_RANK : 4;
  localparam int OW       = npag_pkg::OFF_W;

  typedef enum logic [1:0] {
    S_RUN,
    S_STRIDE,
    S_DELTA,
    S_FIRST
  } state_t;

  typedef logic [AXIS_BITS-1:0] axis_t;
  typedef logic [OW-1:0]        off_t;
  typedef logic [PW-1:0]        idx_t;

  state_t state_r, state_nxt;
  logic   walk_r, walk_nxt;
  idx_t   cnt_r, cnt_nxt;
  idx_t   perm_r   [MAX_RANK];
  idx_t   perm_nxt [MAX_RANK];
  axis_t  dim_r    [MAX_RANK];
  axis_t  dim_nxt  [MAX_RANK];
  axis_t  osize_r  [MAX_RANK];
  axis_t  osize_nxt[MAX_RANK];
  axis_t  coord_r  [MAX_RANK];
  axis_t  coord_nxt[MAX_RANK];
  off_t   stride_r [MAX_RANK];
  off_t   stride_nxt[MAX_RANK];
  off_t   delta_r  [MAX_RANK];
  off_t   delta_nxt[MAX_RANK];
  off_t   wrap_r, wrap_nxt;
  off_t   src_r, src_nxt;
  off_t   dest_r, dest_nxt;

  logic   out_valid_r, out_valid_nxt;
  off_t   out_src_r, out_src_nxt;
  off_t   out_dest_r, out_dest_nxt;
  logic   out_last_r, out_last_nxt;
  logic   out_err_r, out_err_nxt;

  // restart decode
  logic   bad_c, empty_c;
  idx_t   perm_c [MAX_RANK];
  axis_t  dim_c  [MAX_RANK];
  axis_t  osize_c[MAX_RANK];

  // odometer step
  logic   last_c;
  idx_t   carry_c;
  axis_t  step_c [MAX_RANK];

  logic   can_emit, emit_go;
  idx_t   stride_idx;
  off_t   stride_sel, dim_ext, m1_ext;

  always_comb begin
    logic [3:0] n, r, nd;
    logic [3:0] nib   [4];
    logic [1:0] given [4];
    logic [1:0] inv   [4];
    logic [1:0] chosen[4];
    n = cfg.perm_length;
    bad_c = (n == 4'd0) || (n > 4'(RANK_CAP));
    for (int i = 0; i < 4; i++) begin
      nib[i]   = cfg.perm_fields[4*i +: 4];
      given[i] = 2'(nib[i] - 4'd1);
    end
    for (int i = 0; i < 4; i++) begin
      if (4'(i) < n) begin
        if (nib[i] == 4'd0 || nib[i] > n) begin
          bad_c = 1'b1;
        end
        for (int j = 0; j < i; j++) begin
          if (nib[j] == nib[i]) begin
            bad_c = 1'b1;
          end
        end
      end
    end
    for (int i = 0; i < 4; i++) begin
      inv[i] = 2'd0;
      for (int j = 0; j < 4; j++) begin
        if (4'(j) < n && given[j] == 2'(i)) begin
          inv[i] = 2'(j);
        end
      end
      chosen[i] = cfg.inverse_mode ? inv[i] : given[i];
    end
    // clamp rank, then walk over the larger of rank and permutation length
    r = {1'b0, cfg.array_rank};
    if (r < 4'd2) begin
      r = 4'd2;
    end
    if (r > 4'(RANK_CAP)) begin
      r = 4'(RANK_CAP);
    end
    nd = (r > n) ? r : n;
    for (int k = 0; k < MAX_RANK; k++) begin
      if (k < 4 && 4'(k) < n) begin
        perm_c[k] = PW'(chosen[k % 4]);
      end else begin
        perm_c[k] = PW'(k);
      end
      if (k < 4 && 4'(k) < nd) begin
        dim_c[k] = AXIS_BITS'(cfg.axis_size[k % 4]);
      end else begin
        dim_c[k] = axis_t'(1);
      end
    end
    empty_c = 1'b0;
    for (int k = 0; k < MAX_RANK; k++) begin
      osize_c[k] = dim_c[perm_c[k]];
      if (dim_c[k] == '0) begin
        empty_c = 1'b1;
      end
    end
  end

  always_comb begin
    logic found;
    last_c  = 1'b1;
    found   = 1'b0;
    carry_c = '0;
    for (int k = 0; k < MAX_RANK; k++) begin
      step_c[k] = coord_r[k];
      if (coord_r[k] != osize_r[k] - axis_t'(1)) begin
        last_c = 1'b0;
      end
      if (!found) begin
        if (coord_r[k] == osize_r[k] - axis_t'(1)) begin
          step_c[k] = '0;
        end else begin
          step_c[k] = coord_r[k] + axis_t'(1);
          carry_c   = PW'(k);
          found     = 1'b1;
        end
      end
    end
  end

  assign can_emit   = !out_valid_r || out_tready;
  assign cmd_pop    = (state_r == S_RUN) && cmd.valid && can_emit;
  assign emit_go    = ((state_r == S_FIRST) && can_emit) ||
                      (cmd_pop && cmd.kind == npag_pkg::CMD_ADVANCE && walk_r);
  assign stride_idx = (state_r == S_STRIDE) ? (cnt_r - idx_t'(1)) : perm_r[cnt_r];
  assign stride_sel = stride_r[stride_idx];
  assign dim_ext    = OW'(dim_r[cnt_r - idx_t'(1)]);
  assign m1_ext     = OW'(osize_r[cnt_r] - axis_t'(1));

  always_comb begin
    state_nxt     = state_r;
    walk_nxt      = walk_r;
    cnt_nxt       = cnt_r;
    wrap_nxt      = wrap_r;
    src_nxt       = src_r;
    dest_nxt      = dest_r;
    perm_nxt      = perm_r;
    dim_nxt       = dim_r;
    osize_nxt     = osize_r;
    coord_nxt     = coord_r;
    stride_nxt    = stride_r;
    delta_nxt     = delta_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_src_nxt   = out_src_r;
    out_dest_nxt  = out_dest_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;

    case (state_r)
      S_RUN: begin
        if (cmd_pop && cmd.kind == npag_pkg::CMD_RESTART) begin
          walk_nxt = 1'b0;
          if (bad_c) begin
            out_valid_nxt = 1'b1;
            out_src_nxt   = '0;
            out_dest_nxt  = '0;
            out_last_nxt  = 1'b0;
            out_err_nxt   = 1'b1;
          end else if (!empty_c) begin
            perm_nxt      = perm_c;
            dim_nxt       = dim_c;
            osize_nxt     = osize_c;
            stride_nxt[0] = off_t'(1);
            cnt_nxt       = idx_t'(1);
            wrap_nxt      = '0;
            src_nxt       = '0;
            dest_nxt      = '0;
            for (int k = 0; k < MAX_RANK; k++) begin
              coord_nxt[k] = '0;
            end
            state_nxt = S_STRIDE;
          end
        end
      end
      S_STRIDE: begin
        // stride[k] = stride[k-1] * size[k-1], one axis per cycle
        stride_nxt[cnt_r] = stride_sel * dim_ext;
        if (cnt_r == idx_t'(MAX_RANK - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DELTA;
        end else begin
          cnt_nxt = cnt_r + idx_t'(1);
        end
      end
      S_DELTA: begin
        // source jump when axis k advances and all faster axes wrap to zero
        delta_nxt[cnt_r] = stride_sel - wrap_r;
        wrap_nxt         = wrap_r + stride_sel * m1_ext;
        if (cnt_r == idx_t'(MAX_RANK - 1)) begin
          cnt_nxt   = '0;
          walk_nxt  = 1'b1;
          state_nxt = S_FIRST;
        end else begin
          cnt_nxt = cnt_r + idx_t'(1);
        end
      end
      S_FIRST: begin
        if (can_emit) begin
          state_nxt = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
        walk_nxt  = 1'b0;
      end
    endcase

    if (emit_go) begin
      out_valid_nxt = 1'b1;
      out_src_nxt   = src_r;
      out_dest_nxt  = dest_r;
      out_last_nxt  = last_c;
      out_err_nxt   = 1'b0;
      if (last_c) begin
        walk_nxt = 1'b0;
      end else begin
        coord_nxt = step_c;
        src_nxt   = src_r + delta_r[carry_c];
        dest_nxt  = dest_r + off_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      walk_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r      <= cnt_nxt;
    wrap_r     <= wrap_nxt;
    src_r      <= src_nxt;
    dest_r     <= dest_nxt;
    perm_r     <= perm_nxt;
    dim_r      <= dim_nxt;
    osize_r    <= osize_nxt;
    coord_r    <= coord_nxt;
    stride_r   <= stride_nxt;
    delta_r    <= delta_nxt;
    out_src_r  <= out_src_nxt;
    out_dest_r <= out_dest_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_dest_r, out_src_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule

// ===== src/nd_permute_address_generator.sv =====
// Top level of the N-D permute address generator: config registers, front queue, walker.
// Accepted advances are queued, popped by the walker and, in a walk, registered as output.
// Throughput: one element per cycle during a walk, set by the single-add odometer step,
// while advances wait and output is not stalled. A restart sweeps strides, then deltas, first.
// Reset (synchronous, active low) empties the queue, idles the walk and loads config defaults.
module nd_permute_address_generator #(
  parameter int MAX_RANK  = 4,
  parameter int AXIS_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // in_tdata: [0] restart, [7:1] zero
  input  logic [npag_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata: [47:0] source_offset, [95:48] dest_offset
  output logic [npag_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  // out_tuser: [0] perm_error
  output logic                            out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  npag_pkg::cfg_idx_t              cfg_index,
  input  logic [npag_pkg::CFG_DATA_W-1:0] cfg_data
);

  npag_pkg::cfg_t cfg_r, cfg_nxt;
  npag_pkg::cmd_t cmd;
  logic           cmd_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        npag_pkg::CFG_AXIS_SIZE_0:  cfg_nxt.axis_size[0] = cfg_data[11:0];
        npag_pkg::CFG_AXIS_SIZE_1:  cfg_nxt.axis_size[1] = cfg_data[11:0];
        npag_pkg::CFG_AXIS_SIZE_2:  cfg_nxt.axis_size[2] = cfg_data[11:0];
        npag_pkg::CFG_AXIS_SIZE_3:  cfg_nxt.axis_size[3] = cfg_data[11:0];
        npag_pkg::CFG_PERM_FIELDS:  cfg_nxt.perm_fields  = cfg_data;
        npag_pkg::CFG_PERM_LENGTH:  cfg_nxt.perm_length  = cfg_data[3:0];
        npag_pkg::CFG_ARRAY_RANK:   cfg_nxt.array_rank   = cfg_data[2:0];
        npag_pkg::CFG_INVERSE_MODE: cfg_nxt.inverse_mode = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < npag_pkg::CFG_AXES; k++) begin
        cfg_r.axis_size[k] <= npag_pkg::RST_AXIS_SIZE;
      end
      cfg_r.perm_fields  <= npag_pkg::RST_PERM_FIELDS;
      cfg_r.perm_length  <= npag_pkg::RST_PERM_LENGTH;
      cfg_r.array_rank   <= npag_pkg::RST_ARRAY_RANK;
      cfg_r.inverse_mode <= npag_pkg::RST_INVERSE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  npag_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  npag_back #(
    .MAX_RANK  (MAX_RANK),
    .AXIS_BITS (AXIS_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`ifndef ASSERT_OFF
  // an error result carries no offsets and no last mark
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (!out_tlast && out_tdata == '0))
    else $error("error result with non-zero payload");

  // reset leaves the output empty and the queue able to take a transfer
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("block not idle after reset");

  // a command is only taken from the queue when one is waiting
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd.valid)
    else $error("walker popped an empty queue");
`endif

endmodule
